// ===== rtl/core/f2prng_pkg.sv =====
// ----------------------------------------------------------------------------
// f2prng_pkg
// Shared constants and types for the 64-bit F2-linear generator.
// ----------------------------------------------------------------------------
package f2prng_pkg;

    localparam int STATE_DEPTH = 35;
    localparam int LAG_MID     = 17;
    localparam int LAG_TEMPER  = 6;
    localparam int SPLIT_BITS  = 23;
    localparam int EXTRA_SHL   = 36;
    localparam int EXTRA_SHR   = 21;
    localparam int TEMPER_SHL  = 6;
    localparam int SEED_SHR    = 62;

    localparam logic [63:0] UPPER_MASK  = 64'hffff_ffff_ffff_ffff << SPLIT_BITS;
    localparam logic [63:0] LOWER_MASK  = ~UPPER_MASK;
    localparam logic [63:0] TWIST_CONST = 64'h7cbe_23eb_ca8a_6d36;
    localparam logic [63:0] TEMPER_MASK = 64'he4e2_242b_6e15_aebe;
    localparam logic [63:0] SEED_MULT   = 64'd6364136223846793005;

    // partial-product phases of the seed multiply
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_HI_LO = 2'd1;
    localparam logic [1:0] PH_LO_HI = 2'd2;

    typedef struct packed {
        logic       draw;       // draw transaction accepted this cycle
        logic       load_seed;  // reseed transaction accepted this cycle
        logic       seed_step;  // seed multiply phase active
        logic [1:0] phase;      // which partial product
        logic       last;       // final word: goes to the extra word
    } f2prng_cmd_t;

endpackage

// ===== rtl/core/f2prng_ctrl.sv =====
// ----------------------------------------------------------------------------
// f2prng_ctrl
// Handshake control and reseed sequencer.
// ----------------------------------------------------------------------------
module f2prng_ctrl #(
    parameter int STATE_DEPTH = f2prng_pkg::STATE_DEPTH,
    parameter int KW          = $clog2(STATE_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    busy,
    output logic [KW-1:0]           seed_k,
    output f2prng_pkg::f2prng_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEED = 1'b1;

    logic          state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [KW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;
    logic          last_word;

    assign busy      = (state_reg == ST_SEED);
    assign in_ready  = !busy && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign seed_k    = k_reg;
    assign last_word = (k_reg == KW'(STATE_DEPTH));

    always_comb
    begin
        cmd.draw      = accept && !func;
        cmd.load_seed = accept && func;
        cmd.seed_step = busy;
        cmd.phase     = phase_reg;
        cmd.last      = last_word;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (accept && !func)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func)
                begin
                    state_next = ST_SEED;
                    phase_next = f2prng_pkg::PH_LO_LO;
                    k_next     = KW'(1);
                end
            end
            ST_SEED:
            begin
                if (phase_reg == f2prng_pkg::PH_LO_HI)
                begin
                    phase_next = f2prng_pkg::PH_LO_LO;
                    if (last_word)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= f2prng_pkg::PH_LO_LO;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/f2prng_dp.sv =====
// ----------------------------------------------------------------------------
// f2prng_dp
// State shift line, draw recurrence, tempering and seed multiplier.
// ----------------------------------------------------------------------------
module f2prng_dp #(
    parameter int STATE_DEPTH = f2prng_pkg::STATE_DEPTH,
    parameter int KW          = $clog2(STATE_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  f2prng_pkg::f2prng_cmd_t cmd,
    input  logic [KW-1:0]           seed_k,
    input  logic [63:0]             seed,
    output logic [63:0]             value
);

    // words_reg[0] is always the word at the current index
    logic [63:0] words_reg [STATE_DEPTH];
    logic [63:0] words_next[STATE_DEPTH];
    logic [63:0] extra_reg, extra_next;
    logic [63:0] prev_reg;
    logic [63:0] acc_reg;
    logic [63:0] value_reg;

    logic [63:0] x, e, w, t;
    logic [63:0] y;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] seed_word;
    logic        shift_en;
    logic [63:0] shift_in;

    // draw recurrence
    always_comb
    begin
        x = (words_reg[0] & f2prng_pkg::UPPER_MASK) |
            (words_reg[1] & f2prng_pkg::LOWER_MASK);
        e = (x >> 1) ^ (x[0] ? f2prng_pkg::TWIST_CONST : 64'd0) ^
            words_reg[f2prng_pkg::LAG_MID] ^
            extra_reg ^ (extra_reg << f2prng_pkg::EXTRA_SHL);
        w = x ^ e ^ (e >> f2prng_pkg::EXTRA_SHR);
        t = w ^ (w << f2prng_pkg::TEMPER_SHL) ^
            (words_reg[f2prng_pkg::LAG_TEMPER] & f2prng_pkg::TEMPER_MASK);
    end

    // seed recurrence, low 64 bits of the product from three 32x32 pieces
    always_comb
    begin
        y = prev_reg ^ (prev_reg >> f2prng_pkg::SEED_SHR);
        case (cmd.phase)
            f2prng_pkg::PH_LO_LO:
            begin
                mul_a = y[31:0];
                mul_b = f2prng_pkg::SEED_MULT[31:0];
            end
            f2prng_pkg::PH_HI_LO:
            begin
                mul_a = y[63:32];
                mul_b = f2prng_pkg::SEED_MULT[31:0];
            end
            f2prng_pkg::PH_LO_HI:
            begin
                mul_a = y[31:0];
                mul_b = f2prng_pkg::SEED_MULT[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod      = {32'd0, mul_a} * {32'd0, mul_b};
        seed_word = acc_reg + {prod[31:0], 32'd0} + {{(64-KW){1'b0}}, seed_k};
    end

    always_comb
    begin
        shift_en   = 1'b0;
        shift_in   = w;
        extra_next = extra_reg;
        if (cmd.draw)
        begin
            shift_en   = 1'b1;
            shift_in   = w;
            extra_next = e;
        end
        else if (cmd.load_seed)
        begin
            shift_en = 1'b1;
            shift_in = seed;
        end
        else if (cmd.seed_step && cmd.phase == f2prng_pkg::PH_LO_HI)
        begin
            if (cmd.last)
            begin
                extra_next = seed_word;
            end
            else
            begin
                shift_en = 1'b1;
                shift_in = seed_word;
            end
        end
        for (int n = 0; n < STATE_DEPTH - 1; n++)
        begin
            words_next[n] = shift_en ? words_reg[n + 1] : words_reg[n];
        end
        words_next[STATE_DEPTH - 1] = shift_en ? shift_in : words_reg[STATE_DEPTH - 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < STATE_DEPTH; n++)
            begin
                words_reg[n] <= '0;
            end
            extra_reg <= '0;
        end
        else
        begin
            words_reg <= words_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            value_reg <= t;
        end
        if (cmd.load_seed)
        begin
            prev_reg <= seed;
        end
        else if (cmd.seed_step && cmd.phase == f2prng_pkg::PH_LO_HI)
        begin
            prev_reg <= seed_word;
        end
        if (cmd.seed_step)
        begin
            if (cmd.phase == f2prng_pkg::PH_LO_LO)
            begin
                acc_reg <= prod;
            end
            else if (cmd.phase == f2prng_pkg::PH_HI_LO)
            begin
                acc_reg <= acc_reg + {prod[31:0], 32'd0};
            end
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/core/f2_linear_prng_64bit_2281.sv =====
// ----------------------------------------------------------------------------
// f2_linear_prng_64bit_2281
// 64-bit F2-linear random generator, 35-word state, draw and reseed requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  input   | in  | in_valid / in_ready  | func (0 draw, 1 reseed), seed[63:0]
//  output  | out | out_valid / out_ready| value[63:0]
//
//  Draws stream one per cycle while no reseed runs and the result register
//  is free or being taken. Reseeding uses the single shared 32x32 multiplier
//  that builds each 64-bit seed product from three partial products.
//  Reset clears state words, extra word and control; zero state draws zeros.
//  A stalled result holds in the output register and blocks further input.
// ----------------------------------------------------------------------------
module f2_linear_prng_64bit_2281 #(
    parameter int STATE_DEPTH = f2prng_pkg::STATE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] seed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] value
);

    localparam int KW = $clog2(STATE_DEPTH + 1);

    // The state is kept as a rotating shift line: position 0 is always the
    // word at the circular index, so the +1, +6 and +17 neighbours are fixed
    // taps and advancing the index is one shift. A reseed shifts the seed in
    // first and then 34 recurrence words, leaving the index at zero.
    f2prng_pkg::f2prng_cmd_t cmd;
    logic                    busy;
    logic [KW-1:0]           seed_k;

    f2prng_ctrl #(
        .STATE_DEPTH(STATE_DEPTH),
        .KW         (KW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .busy     (busy),
        .seed_k   (seed_k),
        .cmd      (cmd)
    );

    // Datapath: draw recurrence and tempering feed the result register; seed words
    // take three multiply phases each, the last one going to the extra word.
    f2prng_dp #(
        .STATE_DEPTH(STATE_DEPTH),
        .KW         (KW)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .seed_k(seed_k),
        .seed  (seed),
        .value (value)
    );

    // no input transaction while the seed sequencer runs
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("input accepted during reseed");

    // a reseed transaction starts the sequencer
    a_reseed_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func) |=> busy)
        else $error("reseed did not start sequencer");

    // a draw transaction yields a result next cycle, a reseed none
    a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !func) |=> out_valid)
        else $error("draw produced no result");

    a_reseed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func && (!out_valid || out_ready)) |=> !out_valid)
        else $error("reseed produced a result");

endmodule
